// ===== rtl/core/pid_slot_hash_table_assert.svh =====
// assertion macros used by the hash table checker
`ifndef PID_SLOT_HASH_TABLE_ASSERT_SVH
`define PID_SLOT_HASH_TABLE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define PSHT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define PSHT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/psht_pkg.sv =====
// types, sizes and codes of the pid slot hash table
`timescale 1ns / 1ps
package psht_pkg;

  // table geometry
  localparam int unsigned BucketBits    = 8;
  localparam int unsigned BucketCount   = 1 << BucketBits;
  localparam int unsigned Ways          = 4;
  localparam int unsigned WayBits       = (Ways > 1) ? $clog2(Ways) : 1;
  localparam int unsigned FastIndexBits = 16;
  localparam int unsigned FastSize      = 1 << FastIndexBits;
  localparam int unsigned SlotBits      = 10;

  // port widths
  localparam int unsigned ReqW    = 2;
  localparam int unsigned IdW     = 32;
  localparam int unsigned SlotW   = 10;
  localparam int unsigned StatusW = 2;

  // bits of the id that select the bucket start here
  localparam int unsigned HashShift = 4;

  // stored slot width: the port width bounded by the slot size
  localparam int unsigned SlotStoreW = (SlotBits < SlotW) ? SlotBits : SlotW;

  // clear pass sweeps the larger of the two memories
  localparam int unsigned ClrBits =
    (BucketBits > FastIndexBits) ? BucketBits : FastIndexBits;

  typedef enum logic [ReqW-1:0] {
    REQ_LOOKUP = 2'd0,
    REQ_SET    = 2'd1,
    REQ_REMOVE = 2'd2,
    REQ_FAST   = 2'd3
  } req_e;

  typedef enum logic [StatusW-1:0] {
    STS_OK        = 2'd0,
    STS_NOT_FOUND = 2'd1,
    STS_FULL      = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC
  } state_e;

  // one way of a bucket
  typedef struct packed {
    logic                  valid;
    logic [IdW-1:0]        id;
    logic [SlotStoreW-1:0] slot;
  } way_t;

  // one bucket row as held in memory
  typedef way_t [Ways-1:0] row_t;

  // one direct-mapped cache entry
  typedef struct packed {
    logic                  valid;
    logic [SlotStoreW-1:0] slot;
  } fast_t;

endpackage

// ===== rtl/core/psht_ram.sv =====
// simple dual-port synchronous ram, registered read
`timescale 1ns / 1ps
module psht_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// ===== rtl/core/psht_ctrl.sv =====
// request sequencer: clear pass, bucket search, read-modify-write and result register
`timescale 1ns / 1ps
module psht_ctrl (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic [psht_pkg::ReqW-1:0]             req_type_i,
  input  logic [psht_pkg::IdW-1:0]              proc_id_i,
  input  logic [psht_pkg::SlotW-1:0]            slot_in_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic [psht_pkg::StatusW-1:0]          status_o,
  output logic                                  found_o,
  output logic [psht_pkg::SlotW-1:0]            slot_out_o,
  output logic                                  bkt_re_o,
  output logic [psht_pkg::BucketBits-1:0]       bkt_raddr_o,
  output logic                                  bkt_we_o,
  output logic [psht_pkg::BucketBits-1:0]       bkt_waddr_o,
  output psht_pkg::row_t                        bkt_wdata_o,
  input  psht_pkg::row_t                        bkt_rdata_i,
  output logic                                  fst_re_o,
  output logic [psht_pkg::FastIndexBits-1:0]    fst_raddr_o,
  output logic                                  fst_we_o,
  output logic [psht_pkg::FastIndexBits-1:0]    fst_waddr_o,
  output psht_pkg::fast_t                       fst_wdata_o,
  input  psht_pkg::fast_t                       fst_rdata_i
);
  import psht_pkg::*;

  state_e                  state_q, state_d;
  logic [ClrBits-1:0]      clr_q, clr_d;
  logic                    accept;
  logic                    commit;
  logic                    out_free;

  // captured request
  req_e                    req_q;
  logic [IdW-1:0]          id_q;
  logic [SlotStoreW-1:0]   slot_q;

  // result register
  logic                    out_valid_q, out_valid_d;
  status_e                 status_q;
  logic                    found_q;
  logic [SlotStoreW-1:0]   slot_out_q;

  // execute results
  logic                    hit, free;
  logic [WayBits-1:0]      hit_idx, free_idx;
  row_t                    new_row;
  logic                    bkt_wr, fst_wr;
  fast_t                   fst_new;
  status_e                 status_n;
  logic                    found_n;
  logic [SlotStoreW-1:0]   slot_n;

  assign out_free = !out_valid_q || !out_stall_i;
  assign accept   = in_valid_i && !in_stall_o;

  // sequencer
  always_comb begin
    state_d    = state_q;
    clr_d      = clr_q;
    in_stall_o = 1'b1;
    commit     = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        clr_d = clr_q + ClrBits'(1);
        if (&clr_q) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          commit  = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
    end
  end

  // request capture
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q  <= req_e'(req_type_i);
      id_q   <= proc_id_i;
      slot_q <= slot_in_i[SlotStoreW-1:0];
    end
  end

  // memory reads start with the accepted beat
  assign bkt_re_o    = accept;
  assign bkt_raddr_o = proc_id_i[HashShift +: BucketBits];
  assign fst_re_o    = accept;
  assign fst_raddr_o = proc_id_i[FastIndexBits-1:0];

  // way search, lowest way wins
  always_comb begin
    hit      = 1'b0;
    hit_idx  = '0;
    free     = 1'b0;
    free_idx = '0;
    for (int w = Ways - 1; w >= 0; w--) begin
      if (bkt_rdata_i[w].valid && (bkt_rdata_i[w].id == id_q)) begin
        hit     = 1'b1;
        hit_idx = WayBits'(w);
      end
      if (!bkt_rdata_i[w].valid) begin
        free     = 1'b1;
        free_idx = WayBits'(w);
      end
    end
  end

  // request decode and row update
  always_comb begin
    new_row  = bkt_rdata_i;
    bkt_wr   = 1'b0;
    fst_wr   = 1'b0;
    fst_new  = '0;
    status_n = STS_NOT_FOUND;
    found_n  = 1'b0;
    slot_n   = '0;
    unique case (req_q)
      REQ_LOOKUP: begin
        if (hit) begin
          status_n = STS_OK;
          found_n  = 1'b1;
          slot_n   = bkt_rdata_i[hit_idx].slot;
        end
      end
      REQ_SET: begin
        if (hit) begin
          new_row[hit_idx].slot = slot_q;
        end else if (free) begin
          new_row[free_idx].valid = 1'b1;
          new_row[free_idx].id    = id_q;
          new_row[free_idx].slot  = slot_q;
        end
        if (hit || free) begin
          bkt_wr        = 1'b1;
          fst_wr        = 1'b1;
          fst_new.valid = 1'b1;
          fst_new.slot  = slot_q;
          status_n      = STS_OK;
        end else begin
          status_n = STS_FULL;
        end
      end
      REQ_REMOVE: begin
        if (hit) begin
          new_row[hit_idx].valid = 1'b0;
          bkt_wr   = 1'b1;
          fst_wr   = 1'b1;
          status_n = STS_OK;
        end
      end
      REQ_FAST: begin
        if (fst_rdata_i.valid) begin
          status_n = STS_OK;
          found_n  = 1'b1;
          slot_n   = fst_rdata_i.slot;
        end
      end
      default: begin
        status_n = STS_NOT_FOUND;
      end
    endcase
  end

  // write-back, or zero fill during the clear pass
  always_comb begin
    if (state_q == S_CLEAR) begin
      bkt_we_o    = 1'b1;
      bkt_waddr_o = clr_q[BucketBits-1:0];
      bkt_wdata_o = '0;
      fst_we_o    = 1'b1;
      fst_waddr_o = clr_q[FastIndexBits-1:0];
      fst_wdata_o = '0;
    end else begin
      bkt_we_o    = commit && bkt_wr;
      bkt_waddr_o = id_q[HashShift +: BucketBits];
      bkt_wdata_o = new_row;
      fst_we_o    = commit && fst_wr;
      fst_waddr_o = id_q[FastIndexBits-1:0];
      fst_wdata_o = fst_new;
    end
  end

  // result register
  assign out_valid_d = commit || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      status_q   <= status_n;
      found_q    <= found_n;
      slot_out_q <= slot_n;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign found_o     = found_q;
  assign slot_out_o  = SlotW'(slot_out_q);

endmodule

// ===== rtl/core/pid_slot_hash_table.sv =====
// top level of the pid to domain slot hash table
//
//  beat     | valid       | stall       | payload
//  request  | in_valid_i  | in_stall_o  | req_type_i, proc_id_i, slot_in_i
//  result   | out_valid_o | out_stall_i | status_o, found_o, slot_out_o
//
// the bucket row and cache entry are read on the accepting edge and written
// back when the request commits, one row read-modify-write.
// a finished result sits in an output register; the next request may be
// accepted while it waits, and execution holds while that register is stalled.
// after reset a clearing pass zeros both memories with in_stall_o high.
`timescale 1ns / 1ps
module pid_slot_hash_table (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [psht_pkg::ReqW-1:0]     req_type_i,
  input  logic [psht_pkg::IdW-1:0]      proc_id_i,
  input  logic [psht_pkg::SlotW-1:0]    slot_in_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [psht_pkg::StatusW-1:0]  status_o,
  output logic                          found_o,
  output logic [psht_pkg::SlotW-1:0]    slot_out_o
);
  import psht_pkg::*;

  logic                     bkt_re, bkt_we;
  logic [BucketBits-1:0]    bkt_raddr, bkt_waddr;
  row_t                     bkt_wdata, bkt_rdata;
  logic                     fst_re, fst_we;
  logic [FastIndexBits-1:0] fst_raddr, fst_waddr;
  fast_t                    fst_wdata, fst_rdata;

  // sequencer and datapath
  psht_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .req_type_i  (req_type_i),
    .proc_id_i   (proc_id_i),
    .slot_in_i   (slot_in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_o    (status_o),
    .found_o     (found_o),
    .slot_out_o  (slot_out_o),
    .bkt_re_o    (bkt_re),
    .bkt_raddr_o (bkt_raddr),
    .bkt_we_o    (bkt_we),
    .bkt_waddr_o (bkt_waddr),
    .bkt_wdata_o (bkt_wdata),
    .bkt_rdata_i (bkt_rdata),
    .fst_re_o    (fst_re),
    .fst_raddr_o (fst_raddr),
    .fst_we_o    (fst_we),
    .fst_waddr_o (fst_waddr),
    .fst_wdata_o (fst_wdata),
    .fst_rdata_i (fst_rdata)
  );

  // bucket rows, all ways of a bucket in one word
  psht_ram #(
    .Width ($bits(row_t)),
    .Depth (BucketCount)
  ) u_bucket_ram (
    .clk_i   (clk_i),
    .we_i    (bkt_we),
    .waddr_i (bkt_waddr),
    .wdata_i (bkt_wdata),
    .re_i    (bkt_re),
    .raddr_i (bkt_raddr),
    .rdata_o (bkt_rdata)
  );

  // direct-mapped fast cache
  psht_ram #(
    .Width ($bits(fast_t)),
    .Depth (FastSize)
  ) u_fast_ram (
    .clk_i   (clk_i),
    .we_i    (fst_we),
    .waddr_i (fst_waddr),
    .wdata_i (fst_wdata),
    .re_i    (fst_re),
    .raddr_i (fst_raddr),
    .rdata_o (fst_rdata)
  );

endmodule

// ===== rtl/core/psht_checker.sv =====
// port-level checks of the hash table, bound to the top level
`timescale 1ns / 1ps
`include "pid_slot_hash_table_assert.svh"
module psht_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [psht_pkg::StatusW-1:0]  status_o,
  input logic                          found_o,
  input logic [psht_pkg::SlotW-1:0]    slot_out_o
);
  import psht_pkg::*;

  // one request in flight: an accepted beat closes the input next cycle
  `PSHT_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o, "accept not followed by stall")

  // a hit always reports ok
  `PSHT_ASSERT_NOW(a_found_ok, out_valid_o && found_o, status_o == STS_OK, "found with bad status")

  // misses and non-lookups carry a zero slot
  `PSHT_ASSERT_NOW(a_miss_zero, out_valid_o && !found_o, slot_out_o == '0, "slot on miss")

  // full is only reported when nothing was found
  `PSHT_ASSERT_NOW(a_full_nohit, out_valid_o && status_o == STS_FULL, !found_o, "full with hit")

  // a stalled result stays presented
  `PSHT_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o, "result dropped")

endmodule

bind pid_slot_hash_table psht_checker u_checker (.*);
